>>> rtl/scsl_pkg.sv
// scsl_pkg: shared constants and types for the scaled color sample log
// command and result codes, record layout and default log depth
// no dependencies
`default_nettype none

package scsl_pkg;

    localparam int LOG_DEPTH_DEFAULT = 64;
    localparam int COUNT_W           = 6;

    localparam logic [2:0] OP_STORE     = 3'd0;
    localparam logic [2:0] OP_CLEAR     = 3'd1;
    localparam logic [2:0] OP_COUNT     = 3'd2;
    localparam logic [2:0] OP_READ_LAST = 3'd3;
    localparam logic [2:0] OP_READ_ALL  = 3'd4;

    localparam logic [1:0] KIND_ECHO   = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_COUNT  = 2'd2;
    localparam logic [1:0] KIND_RECORD = 2'd3;

    localparam logic [6:0] PCT_MAX = 7'd99;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [6:0] red;
        logic [6:0] green;
        logic [6:0] blue;
    } rec_t;

    typedef struct packed {
        logic [1:0]         kind;
        rec_t               rec;
        logic [COUNT_W-1:0] stored_count;
        logic               empty_res;
        logic               last;
    } out_item_t;

endpackage

`default_nettype wire

>>> rtl/scsl_if.sv
// scsl_cmd_if and scsl_res_if: valid/ready channels of the sample log
// command channel carries op, raw samples and time stamp; result channel the record
// no dependencies
`default_nettype none

interface scsl_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] red_raw;
    logic [7:0] green_raw;
    logic [7:0] blue_raw;
    logic [4:0] clock_hour;
    logic [5:0] clock_minute;
    logic [5:0] clock_second;

    modport source (
        output valid, op, red_raw, green_raw, blue_raw,
               clock_hour, clock_minute, clock_second,
        input  ready
    );
    modport sink (
        input  valid, op, red_raw, green_raw, blue_raw,
               clock_hour, clock_minute, clock_second,
        output ready
    );
endinterface

interface scsl_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [4:0] rec_hour;
    logic [5:0] rec_minute;
    logic [5:0] rec_second;
    logic [6:0] red_pct;
    logic [6:0] green_pct;
    logic [6:0] blue_pct;
    logic [5:0] stored_count;
    logic       empty_res;
    logic       last;

    modport source (
        output valid, kind, rec_hour, rec_minute, rec_second,
               red_pct, green_pct, blue_pct, stored_count, empty_res, last,
        input  ready
    );
    modport sink (
        input  valid, kind, rec_hour, rec_minute, rec_second,
               red_pct, green_pct, blue_pct, stored_count, empty_res, last,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/scsl_mem.sv
// scsl_mem: record store, one write port and one read port, registered read data
// depends on scsl_pkg for the record type
`default_nettype none

module scsl_mem #(
    parameter int DEPTH  = scsl_pkg::LOG_DEPTH_DEFAULT,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire                 clk,
    input  wire                 we,
    input  wire [ADDR_W-1:0]    waddr,
    input  scsl_pkg::rec_t      wdata,
    input  wire                 re,
    input  wire [ADDR_W-1:0]    raddr,
    output scsl_pkg::rec_t      rdata
);
    import scsl_pkg::*;

    rec_t store_mem [DEPTH];
    rec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/scsl_ctrl.sv
// scsl_ctrl: command sequencer of the sample log, pointer state and output register
// depends on scsl_pkg and the scsl_cmd_if / scsl_res_if channels
`default_nettype none

module scsl_ctrl #(
    parameter int LOG_DEPTH = scsl_pkg::LOG_DEPTH_DEFAULT,
    parameter int PTR_W     = $clog2(LOG_DEPTH)
) (
    input  wire                 clk,
    input  wire                 rst_n,
    scsl_cmd_if.sink            cmd,
    scsl_res_if.source          res,
    output logic                mem_we,
    output logic [PTR_W-1:0]    mem_waddr,
    output scsl_pkg::rec_t      mem_wdata,
    output logic                mem_re,
    output logic [PTR_W-1:0]    mem_raddr,
    input  scsl_pkg::rec_t      mem_rdata
);
    import scsl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RDLAST = 3'b010,
        ST_WALK   = 3'b100
    } state_t;

    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(LOG_DEPTH - 1);

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic             wrapped_reg, wrapped_next;
    logic [PTR_W-1:0] walk_reg, walk_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;

    logic             slot_free;
    logic             accept;
    logic [PTR_W-1:0] ptr_inc;
    logic [PTR_W-1:0] walk_inc;
    rec_t             new_rec;

    // floor(v*99/255), reciprocal form exact for 15-bit numerators
    function automatic logic [6:0] scale_channel(input logic [7:0] v);
        logic [14:0] prod;
        logic [15:0] sum;
        logic [7:0]  quo;
        prod = 15'(v) * 15'd99;
        sum  = 16'(prod) + 16'(prod >> 8) + 16'd1;
        quo  = sum[15:8];
        return (quo > 8'(PCT_MAX)) ? PCT_MAX : quo[6:0];
    endfunction

    function automatic out_item_t make_item(
        input logic [1:0]         kind,
        input rec_t               rec,
        input logic [COUNT_W-1:0] count,
        input logic               empty,
        input logic               last
    );
        out_item_t item;
        item.kind         = kind;
        item.rec          = rec;
        item.stored_count = count;
        item.empty_res    = empty;
        item.last         = last;
        return item;
    endfunction

    assign slot_free = !out_valid_reg || res.ready;
    assign cmd.ready = (state_reg == ST_IDLE) && slot_free;
    assign accept    = cmd.valid && cmd.ready;
    assign ptr_inc   = ptr_reg + 1'b1;
    assign walk_inc  = walk_reg + 1'b1;

    always_comb
    begin
        new_rec.hour   = cmd.clock_hour;
        new_rec.minute = cmd.clock_minute;
        new_rec.second = cmd.clock_second;
        new_rec.red    = scale_channel(cmd.red_raw);
        new_rec.green  = scale_channel(cmd.green_raw);
        new_rec.blue   = scale_channel(cmd.blue_raw);
    end

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        wrapped_next   = wrapped_reg;
        walk_next      = walk_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = ptr_reg;
        mem_wdata      = new_rec;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.op)
                        OP_STORE:
                        begin
                            mem_we = 1'b1;
                            if (ptr_reg == LAST_IDX)
                            begin
                                ptr_next     = '0;
                                wrapped_next = 1'b1;
                            end
                            else
                            begin
                                ptr_next = ptr_inc;
                            end
                            out_next = make_item(KIND_ECHO, new_rec,
                                                 COUNT_W'(ptr_next), 1'b0, 1'b1);
                            out_valid_next = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            ptr_next       = '0;
                            wrapped_next   = 1'b0;
                            out_next       = make_item(KIND_CLEAR, '0, '0, 1'b0, 1'b1);
                            out_valid_next = 1'b1;
                        end
                        OP_COUNT:
                        begin
                            out_next = make_item(KIND_COUNT, '0,
                                                 COUNT_W'(ptr_reg), 1'b0, 1'b1);
                            out_valid_next = 1'b1;
                        end
                        OP_READ_LAST:
                        begin
                            if (ptr_reg != '0 || wrapped_reg)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = (ptr_reg != '0) ? ptr_reg - 1'b1 : LAST_IDX;
                                state_next = ST_RDLAST;
                            end
                            else
                            begin
                                out_next = make_item(KIND_RECORD, '0,
                                                     COUNT_W'(ptr_reg), 1'b1, 1'b1);
                                out_valid_next = 1'b1;
                            end
                        end
                        OP_READ_ALL:
                        begin
                            if (ptr_reg != '0)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                                walk_next  = '0;
                                state_next = ST_WALK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RDLAST:
            begin
                if (slot_free)
                begin
                    out_next = make_item(KIND_RECORD, mem_rdata,
                                         COUNT_W'(ptr_reg), 1'b0, 1'b1);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_WALK:
            begin
                if (slot_free)
                begin
                    out_next = make_item(KIND_RECORD, mem_rdata, COUNT_W'(ptr_reg),
                                         1'b0, walk_inc == ptr_reg);
                    out_valid_next = 1'b1;
                    if (walk_inc == ptr_reg)
                    begin
                        walk_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        walk_next = walk_inc;
                        mem_re    = 1'b1;
                        mem_raddr = walk_inc;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            wrapped_reg   <= 1'b0;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            wrapped_reg   <= wrapped_next;
            walk_reg      <= walk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.kind         = out_reg.kind;
    assign res.rec_hour     = out_reg.rec.hour;
    assign res.rec_minute   = out_reg.rec.minute;
    assign res.rec_second   = out_reg.rec.second;
    assign res.red_pct      = out_reg.rec.red;
    assign res.green_pct    = out_reg.rec.green;
    assign res.blue_pct     = out_reg.rec.blue;
    assign res.stored_count = out_reg.stored_count;
    assign res.empty_res    = out_reg.empty_res;
    assign res.last         = out_reg.last;

endmodule

`default_nettype wire

>>> rtl/scaled_color_sample_log.sv
// scaled_color_sample_log: top level of the circular color sample log
// depends on scsl_pkg, scsl_if, scsl_mem and scsl_ctrl
//
// usage
//   cmd: valid/ready channel with op, raw red/green/blue and an h:m:s stamp
//   res: valid/ready channel with one result per command, or one per entry
//     for read-all, the final one marked by last
//   store, clear, count and an empty read-last give their result in the cycle
//   after the transfer; the result sits in an output register, and the next
//   command is taken as res takes it, one command per cycle unless res stalls
//   read-last reads the record store into its registered read data, then
//   answers through the output register; read-all does the same for its first
//   entry, then one entry a cycle unless res stalls, set by the single read port
//   read-all walks entries below the pointer only; at zero it gives no result
//   while res is stalled the output register holds and the sequencer waits;
//   cmd.ready stays low until the output register can be refilled
//   reset clears the pointer, wrap mark and output valid; record contents are
//   left as they are and no clearing pass runs
`default_nettype none

module scaled_color_sample_log #(
    parameter int LOG_DEPTH = scsl_pkg::LOG_DEPTH_DEFAULT
) (
    input  wire         clk,
    input  wire         rst_n,
    scsl_cmd_if.sink    cmd,
    scsl_res_if.source  res
);
    import scsl_pkg::*;

    localparam int PTR_W = $clog2(LOG_DEPTH);

    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    rec_t             mem_wdata;
    logic             mem_re;
    logic [PTR_W-1:0] mem_raddr;
    rec_t             mem_rdata;

    scsl_ctrl #(
        .LOG_DEPTH (LOG_DEPTH),
        .PTR_W     (PTR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    scsl_mem #(
        .DEPTH  (LOG_DEPTH),
        .ADDR_W (PTR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

>>> rtl/scsl_check.sv
// scsl_check: port-level assertions for scaled_color_sample_log, bound to the top
// depends on scsl_pkg for the result kind codes
`default_nettype none

module scsl_check (
    input wire       clk,
    input wire       rst_n,
    input wire       res_valid,
    input wire       res_ready,
    input wire [1:0] res_kind,
    input wire [6:0] res_red_pct,
    input wire [6:0] res_green_pct,
    input wire [6:0] res_blue_pct,
    input wire [5:0] res_stored_count,
    input wire       res_empty_res,
    input wire       res_last
);
    import scsl_pkg::*;

    // stalled result keeps its valid, kind, last and stored count
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_last)
            && $stable(res_stored_count))
        else $error("result changed while stalled");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind != KIND_RECORD |-> res_last && !res_empty_res)
        else $error("single result without last or with empty flag");

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_CLEAR |-> res_stored_count == 6'd0)
        else $error("clear ack with nonzero count");

    a_empty_rec: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_empty_res |-> res_kind == KIND_RECORD && res_last
            && res_stored_count == 6'd0 && res_red_pct == 7'd0)
        else $error("empty read-last result malformed");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_red_pct <= PCT_MAX && res_green_pct <= PCT_MAX
            && res_blue_pct <= PCT_MAX)
        else $error("scaled level above range");

endmodule

bind scaled_color_sample_log scsl_check u_scsl_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .res_kind         (res.kind),
    .res_red_pct      (res.red_pct),
    .res_green_pct    (res.green_pct),
    .res_blue_pct     (res.blue_pct),
    .res_stored_count (res.stored_count),
    .res_empty_res    (res.empty_res),
    .res_last         (res.last)
);

`default_nettype wire
